>>> sv/fscs_pkg.sv
// shared types, material and op codes, rectangle reset values for the chunk step unit
// no dependencies
package fscs_pkg;

  localparam int CHUNK_BITS = 6;
  localparam int CHUNK_SIZE = 64;
  localparam int CHUNKS_WIDE = 4;
  localparam int CHUNKS_HIGH = 4;
  localparam int NCHUNKS = CHUNKS_WIDE * CHUNKS_HIGH;
  localparam int CIDX_BITS = 2;
  localparam int CHUNK_IDX_BITS = 2 * CIDX_BITS;
  localparam int ADDR_BITS = 16;

  typedef logic [2:0] mat_t;
  localparam mat_t MAT_EMPTY = 3'd0;
  localparam mat_t MAT_WALL  = 3'd1;
  localparam mat_t MAT_SAND  = 3'd2;
  localparam mat_t MAT_WATER = 3'd3;
  localparam mat_t MAT_GAS   = 3'd4;

  typedef logic [1:0] op_t;
  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_STEP  = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  typedef logic signed [7:0] rcoord_t;

  typedef struct packed {
    rcoord_t min_x;
    rcoord_t min_y;
    rcoord_t max_x;
    rcoord_t max_y;
  } rect_t;

  localparam rect_t CUR_RST  = '{8'sd0, 8'sd0, 8'sd63, 8'sd63};
  localparam rect_t NEXT_RST = '{8'sd64, 8'sd64, -8'sd1, -8'sd1};

  typedef struct packed {
    logic                 we_cell;
    logic                 we_mark;
    logic [ADDR_BITS-1:0] addr;
    mat_t                 wdata;
    logic                 mark;
  } cell_req_t;

  typedef struct packed {
    logic                      valid;
    logic [CHUNK_IDX_BITS-1:0] chunk;
    logic [CHUNK_BITS-1:0]     lx;
    logic [CHUNK_BITS-1:0]     ly;
  } wake_req_t;

  function automatic logic may_enter(mat_t mover, mat_t target);
    logic r;
    r = 1'b0;
    if (target != MAT_WALL) begin
      if (mover == MAT_SAND)
        r = (target == MAT_EMPTY) || (target == MAT_WATER) || (target == MAT_GAS);
      else if (mover == MAT_WATER)
        r = (target == MAT_EMPTY) || (target == MAT_GAS);
      else if (mover == MAT_GAS)
        r = (target == MAT_EMPTY);
    end
    return r;
  endfunction

endpackage

>>> sv/fscs_cells.sv
// cell material store and moved marks, one shared address, registered read
// depends on fscs_pkg
module fscs_cells (
  input  logic                clk,
  input  fscs_pkg::cell_req_t req,
  output fscs_pkg::mat_t      rd_cell,
  output logic                rd_mark
);

  fscs_pkg::mat_t cell_mem [2**fscs_pkg::ADDR_BITS];
  logic           mark_mem [2**fscs_pkg::ADDR_BITS];

  always_ff @(posedge clk) begin
    if (req.we_cell) cell_mem[req.addr] <= req.wdata;
    rd_cell <= cell_mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (req.we_mark) mark_mem[req.addr] <= req.mark;
    rd_mark <= mark_mem[req.addr];
  end

endmodule

>>> sv/fscs_rect.sv
// per-chunk dirty rectangles: current and next, one wake point merged per cycle unless rst or commit
// depends on fscs_pkg
module fscs_rect (
  input  logic                                      clk,
  input  logic                                      rst,
  input  fscs_pkg::wake_req_t                       wake,
  input  logic                                      commit,
  input  logic [fscs_pkg::CHUNK_IDX_BITS-1:0]       sel,
  output fscs_pkg::rect_t                           cur
);

  fscs_pkg::rect_t cur_r  [fscs_pkg::NCHUNKS];
  fscs_pkg::rect_t next_r [fscs_pkg::NCHUNKS];
  fscs_pkg::rcoord_t px, py;

  assign px = fscs_pkg::rcoord_t'({2'b00, wake.lx});
  assign py = fscs_pkg::rcoord_t'({2'b00, wake.ly});
  assign cur = cur_r[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < fscs_pkg::NCHUNKS; k++) begin
        cur_r[k]  <= fscs_pkg::CUR_RST;
        next_r[k] <= fscs_pkg::NEXT_RST;
      end
    end else if (commit) begin
      for (int k = 0; k < fscs_pkg::NCHUNKS; k++) begin
        cur_r[k]  <= next_r[k];
        next_r[k] <= fscs_pkg::NEXT_RST;
      end
    end else if (wake.valid) begin
      if (px < next_r[wake.chunk].min_x) next_r[wake.chunk].min_x <= px;
      if (py < next_r[wake.chunk].min_y) next_r[wake.chunk].min_y <= py;
      if (px > next_r[wake.chunk].max_x) next_r[wake.chunk].max_x <= px;
      if (py > next_r[wake.chunk].max_y) next_r[wake.chunk].max_y <= py;
    end
  end

endmodule

>>> sv/falling_sand_chunk_step_unit.sv
// channel | dir | signals                           | content
// in      | in  | s_tvalid s_tready s_tuser s_tdata | op; x, y, material
// out     | out | m_tvalid m_tready m_tdata         | cell_value, accepted
// a step clears the moved marks, then sweeps each awake chunk's rectangle from the
// bottom row up, tries the neighbors of each moving cell inside the grid in turn and
// swaps on the first one it may enter; every access goes through the single port of
// the cell store shared by every access
// reset: after rst a clearing pass writes the border and interior before the first
// item is taken; one item at a time, output held until taken
// depends on fscs_pkg, fscs_cells, fscs_rect
module falling_sand_chunk_step_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] op
  input  logic [23:0] s_tdata,   // [7:0] x, [15:8] y, [18:16] material, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [2:0] cell_value, [3] accepted, rest zero
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_WRITE, S_READ, S_READ_DATA, S_MCLR, S_CHUNK, S_CELL_RD,
    S_CELL_EVAL, S_CAND, S_TGT, S_SWAP2, S_WAKE, S_NEXT, S_NEXT_CHUNK, S_COMMIT,
    S_RESP
  } state_t;

  state_t state;
  logic [fscs_pkg::ADDR_BITS-1:0] cnt;
  fscs_pkg::op_t  iop;
  logic [7:0]     ix, iy;
  fscs_pkg::mat_t imat;
  fscs_pkg::mat_t res_cell;
  logic           res_acc;
  logic           parity;
  logic [fscs_pkg::CIDX_BITS-1:0]  cx, cy;
  logic [fscs_pkg::CHUNK_BITS-1:0] lx, ly;
  fscs_pkg::mat_t self_mat, tgt;
  logic [2:0]     cand;
  logic [7:0]     tx, ty, wx, wy;
  logic [1:0]     wdx, wdy;
  logic           wtwo;
  logic [2:0]     out_cell;
  logic           out_acc;

  fscs_pkg::cell_req_t req;
  fscs_pkg::mat_t      rd_cell;
  logic                rd_mark;
  fscs_pkg::wake_req_t wake;
  logic                commit;
  fscs_pkg::rect_t     rect;

  logic [7:0] cur_x, cur_y;
  logic       awake, left_first, go_left, go_right, border_in, ends;
  logic [8:0] tx9, ty9, nx9, ny9;
  logic [2:0] in_mat;
  logic [7:0] in_x, in_y;

  fscs_cells u_cells (.clk(clk), .req(req), .rd_cell(rd_cell), .rd_mark(rd_mark));

  fscs_rect u_rect (
    .clk(clk), .rst(rst), .wake(wake), .commit(commit), .sel({cy, cx}), .cur(rect)
  );

  assign in_x   = s_tdata[7:0];
  assign in_y   = s_tdata[15:8];
  assign in_mat = s_tdata[18:16];
  assign m_tdata = {4'b0000, out_acc, out_cell};
  assign s_tready = (state == S_IDLE);

  assign cur_x = {cx, lx};
  assign cur_y = {cy, ly};
  assign awake = (rect.min_x <= rect.max_x) && (rect.min_y <= rect.max_y);
  assign border_in = (in_x == 8'd0) || (in_y == 8'd0) || (in_x == 8'hFF) || (in_y == 8'hFF);

  // first side tried is left when x + y + parity is even
  assign left_first = ~(lx[0] ^ ly[0] ^ parity);
  always_comb begin
    go_left  = 1'b0;
    go_right = 1'b0;
    if (cand == 3'd1 || cand == 3'd3) begin
      go_left  = left_first;
      go_right = ~left_first;
    end else if (cand == 3'd2 || cand == 3'd4) begin
      go_left  = ~left_first;
      go_right = left_first;
    end
    tx9 = {1'b0, cur_x};
    if (go_left) tx9 = {1'b0, cur_x} - 9'd1;
    else if (go_right) tx9 = {1'b0, cur_x} + 9'd1;
    ty9 = {1'b0, cur_y};
    if (cand < 3'd3) begin
      if (self_mat == fscs_pkg::MAT_GAS) ty9 = {1'b0, cur_y} - 9'd1;
      else ty9 = {1'b0, cur_y} + 9'd1;
    end
    ends = (self_mat == fscs_pkg::MAT_SAND) ? (cand > 3'd2) : (cand > 3'd4);
  end

  assign nx9 = {1'b0, wx} + {7'b0, wdx} - 9'd1;
  assign ny9 = {1'b0, wy} + {7'b0, wdy} - 9'd1;

  always_comb begin
    req    = '0;
    wake   = '0;
    commit = 1'b0;
    unique case (state)
      S_INIT: begin
        req.addr    = cnt;
        req.we_cell = 1'b1;
        req.we_mark = 1'b1;
        req.wdata   = (cnt[7:0] == 8'd0 || cnt[15:8] == 8'd0 || cnt[7:0] == 8'hFF ||
                       cnt[15:8] == 8'hFF) ? fscs_pkg::MAT_WALL : fscs_pkg::MAT_EMPTY;
      end
      S_MCLR: begin
        req.addr    = cnt;
        req.we_mark = 1'b1;
      end
      S_WRITE: begin
        req.addr    = {iy, ix};
        req.we_cell = 1'b1;
        req.wdata   = imat;
      end
      S_READ:    req.addr = {iy, ix};
      S_CELL_RD: req.addr = {cur_y, cur_x};
      S_CAND:    req.addr = {ty9[7:0], tx9[7:0]};
      S_TGT: begin
        req.addr  = {ty, tx};
        req.wdata = self_mat;
        req.mark  = 1'b1;
        if (!rd_mark && fscs_pkg::may_enter(self_mat, rd_cell)) begin
          req.we_cell = 1'b1;
          req.we_mark = 1'b1;
        end
      end
      S_SWAP2: begin
        req.addr    = {cur_y, cur_x};
        req.wdata   = tgt;
        req.mark    = 1'b1;
        req.we_cell = 1'b1;
        req.we_mark = 1'b1;
      end
      S_WAKE: begin
        wake.valid = ~nx9[8] & ~ny9[8];
        wake.chunk = {ny9[7:6], nx9[7:6]};
        wake.lx    = nx9[5:0];
        wake.ly    = ny9[5:0];
      end
      S_COMMIT: commit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      cnt      <= '0;
      m_tvalid <= 1'b0;
      parity   <= 1'b0;
    end else begin
      if (state == S_RESP && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            iop      <= s_tuser;
            ix       <= in_x;
            iy       <= in_y;
            imat     <= in_mat;
            res_cell <= fscs_pkg::MAT_EMPTY;
            res_acc  <= 1'b1;
            cnt      <= '0;
            unique case (s_tuser)
              fscs_pkg::OP_WRITE: begin
                if (in_mat > fscs_pkg::MAT_GAS || border_in) begin
                  res_acc <= 1'b0;
                  state   <= S_RESP;
                end else begin
                  state <= S_WRITE;
                end
              end
              fscs_pkg::OP_STEP: state <= S_MCLR;
              fscs_pkg::OP_READ: state <= S_READ;
              default:           state <= S_RESP;
            endcase
          end
        end
        S_WRITE: begin
          wx    <= ix;
          wy    <= iy;
          wdx   <= 2'd0;
          wdy   <= 2'd0;
          wtwo  <= 1'b0;
          state <= S_WAKE;
        end
        S_READ: state <= S_READ_DATA;
        S_READ_DATA: begin
          res_cell <= rd_cell;
          state    <= S_RESP;
        end
        S_MCLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            cy    <= '1;
            cx    <= '0;
            state <= S_CHUNK;
          end
        end
        S_CHUNK: begin
          if (awake) begin
            lx    <= rect.min_x[fscs_pkg::CHUNK_BITS-1:0];
            ly    <= rect.max_y[fscs_pkg::CHUNK_BITS-1:0];
            state <= S_CELL_RD;
          end else begin
            state <= S_NEXT_CHUNK;
          end
        end
        S_CELL_RD: state <= S_CELL_EVAL;
        S_CELL_EVAL: begin
          self_mat <= rd_cell;
          cand     <= 3'd0;
          if (rd_mark || rd_cell == fscs_pkg::MAT_EMPTY || rd_cell == fscs_pkg::MAT_WALL ||
              rd_cell > fscs_pkg::MAT_GAS)
            state <= S_NEXT;
          else
            state <= S_CAND;
        end
        S_CAND: begin
          if (ends) begin
            state <= S_NEXT;
          end else if (tx9[8] || ty9[8]) begin
            cand <= cand + 3'd1;
          end else begin
            tx    <= tx9[7:0];
            ty    <= ty9[7:0];
            state <= S_TGT;
          end
        end
        S_TGT: begin
          tgt <= rd_cell;
          if (!rd_mark && fscs_pkg::may_enter(self_mat, rd_cell)) begin
            state <= S_SWAP2;
          end else begin
            cand  <= cand + 3'd1;
            state <= S_CAND;
          end
        end
        S_SWAP2: begin
          wx    <= cur_x;
          wy    <= cur_y;
          wdx   <= 2'd0;
          wdy   <= 2'd0;
          wtwo  <= 1'b1;
          state <= S_WAKE;
        end
        S_WAKE: begin
          if (wdx == 2'd2) begin
            wdx <= 2'd0;
            if (wdy == 2'd2) begin
              wdy <= 2'd0;
              if (wtwo) begin
                wtwo <= 1'b0;
                wx   <= tx;
                wy   <= ty;
              end else if (iop == fscs_pkg::OP_STEP) begin
                state <= S_NEXT;
              end else begin
                state <= S_RESP;
              end
            end else begin
              wdy <= wdy + 2'd1;
            end
          end else begin
            wdx <= wdx + 2'd1;
          end
        end
        S_NEXT: begin
          if (lx == rect.max_x[fscs_pkg::CHUNK_BITS-1:0]) begin
            lx <= rect.min_x[fscs_pkg::CHUNK_BITS-1:0];
            if (ly == rect.min_y[fscs_pkg::CHUNK_BITS-1:0]) begin
              state <= S_NEXT_CHUNK;
            end else begin
              ly    <= ly - 1'b1;
              state <= S_CELL_RD;
            end
          end else begin
            lx    <= lx + 1'b1;
            state <= S_CELL_RD;
          end
        end
        S_NEXT_CHUNK: begin
          if (cx == '1) begin
            cx <= '0;
            if (cy == '0) begin
              state <= S_COMMIT;
            end else begin
              cy    <= cy - 1'b1;
              state <= S_CHUNK;
            end
          end else begin
            cx    <= cx + 1'b1;
            state <= S_CHUNK;
          end
        end
        S_COMMIT: begin
          parity <= ~parity;
          state  <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            out_cell <= res_cell;
            out_acc  <= res_acc;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
